>>> rtl/char_framebuffer_rasterizer_assert.svh
// Assertion macros for the character framebuffer rasterizer.
// Every macro expects clk and arst_n to be visible where it is used.
`ifndef CHAR_FRAMEBUFFER_RASTERIZER_ASSERT_SVH
`define CHAR_FRAMEBUFFER_RASTERIZER_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define CFR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CFR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/cfr_pkg.sv
// Shared types and constants of the character framebuffer rasterizer.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package cfr_pkg;

	localparam int CRD_W = 14;	// signed coordinate arithmetic
	localparam int MUL_W = 18;	// operands of the shared multiplier
	localparam int SQ_W  = 27;	// signed squared distances

	localparam logic [7:0]  GLYPH_SPACE = 8'h20;
	localparam logic [7:0]  GLYPH_DOT   = 8'h2E;
	localparam logic [7:0]  GLYPH_HASH  = 8'h23;
	localparam logic [16:0] FRAC_FULL   = 17'd65536;

	localparam logic [1:0] CFG_COLS = 2'd0;
	localparam logic [1:0] CFG_ROWS = 2'd1;

	typedef enum logic [2:0] {
		CMD_CLEAR   = 3'd0,
		CMD_CELL    = 3'd1,
		CMD_RECT    = 3'd2,
		CMD_ELLIPSE = 3'd3,
		CMD_BAR     = 3'd4,
		CMD_SCAN    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		SHAPE_RECT,
		SHAPE_ELLIPSE,
		SHAPE_BAR
	} shape_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WIPE,
		ST_BOUNDS,
		ST_MUL,
		ST_DRAW,
		ST_TOTAL,
		ST_CHECK,
		ST_DIV,
		ST_READ,
		ST_RDATA,
		ST_OUT
	} state_t;

endpackage

>>> rtl/cfr_ifs.sv
// Handshake channels of the character framebuffer rasterizer: commands in, cells out.
// No dependencies.
`timescale 1ns / 1ps

interface cfr_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [10:0] pos_x;
	logic signed [10:0] pos_y;
	logic signed [10:0] extent_w;
	logic signed [10:0] extent_h;
	logic [7:0]         glyph;
	logic [3:0]         ink;
	logic [3:0]         back_ink;
	logic               solid;
	logic [16:0]        fraction;

	modport source (output valid, cmd, pos_x, pos_y, extent_w, extent_h, glyph, ink,
		back_ink, solid, fraction, input ready);
	modport sink (input valid, cmd, pos_x, pos_y, extent_w, extent_h, glyph, ink,
		back_ink, solid, fraction, output ready);
endinterface

interface cfr_cell_if;
	logic       valid;
	logic       ready;
	logic [7:0] cell_glyph;
	logic [3:0] cell_ink;
	logic       ink_changed;
	logic       frame_first;
	logic       row_last;
	logic       frame_last;

	modport source (output valid, cell_glyph, cell_ink, ink_changed, frame_first,
		row_last, frame_last, input ready);
	modport sink (input valid, cell_glyph, cell_ink, ink_changed, frame_first,
		row_last, frame_last, output ready);
endinterface

>>> rtl/cfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cfr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/char_framebuffer_rasterizer.sv
// Top level of the character framebuffer rasterizer: sequencer, draw loop, scan-out.
// Depends on cfr_pkg, the channels in cfr_ifs.sv, cfr_ram and the assertion header.
`timescale 1ns / 1ps

// The block holds MAX_COLS x MAX_ROWS cells (glyph and color) in one RAM and takes one
// command item at a time. After reset a clearing pass writes every cell, one per cycle,
// and commands are refused until it ends; a clear command takes the same sweep. Draw
// commands first clip the box, then form up to three products on the shared multiplier,
// then walk the clipped bounding box cell by cell, writing at most one RAM entry per
// cycle. A scan item reads its cell from the RAM, registers it and holds it on the
// output until it is taken; the first scan after reset or a window register write
// first splits the scan position into row and column with a bit-serial divider, or
// restarts at the first cell if the position lies beyond the window.

`include "char_framebuffer_rasterizer_assert.svh"

module char_framebuffer_rasterizer import cfr_pkg::*; #(
	parameter int MAX_COLS  = 128,
	parameter int MAX_ROWS  = 32,
	parameter int INK_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	cfr_req_if.sink    req,
	cfr_cell_if.source cells
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW    = AW + 1;
	localparam int CW    = $clog2(MAX_COLS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);
	localparam int DCW   = $clog2(AW + 1);

	function automatic logic [3:0] fix_ink(input logic [3:0] k);
		return (32'(k) < INK_COUNT) ? k : 4'd0;
	endfunction

	state_t state_q, state_d;

	logic [7:0] cols_cfg_q;
	logic [5:0] rows_cfg_q;
	logic [CW-1:0] vis_cols;
	logic [RW-1:0] vis_rows;
	logic signed [CRD_W-1:0] cols_s, rows_s;

	// Captured command.
	shape_t shape_q;
	logic signed [CRD_W-1:0] px_q, py_q, ew_q, eh_q;
	logic [7:0] glyph_q;
	logic [3:0] ink_q, bink_q;
	logic solid_q;
	logic [16:0] frac_q;

	// Draw loop.
	logic signed [CRD_W-1:0] x0_q, x1_q, y1_q, x_q, y_q, filled_q;
	logic signed [SQ_W-1:0] lim_q, dxsq0_q, dxsq_q, dysq_q;
	logic [1:0] mstep_q;
	logic signed [CRD_W-1:0] bx0, bx1, by0, by1, dx, dy;
	logic none, empty, interior, hit, row_end;

	// Shared multiplier.
	logic signed [MUL_W-1:0] mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod;

	// Scan position.
	logic [AW-1:0] idx_q, dq_q, wipe_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q, rem_q, rem_n;
	logic [AW-1:0] dq_n;
	logic [CW:0] div_t;
	logic div_ge;
	logic [DCW-1:0] dcnt_q;
	logic [TW-1:0] total_q;
	logic need_div_q;
	logic [3:0] prev_ink_q;
	logic prev_valid_q;
	logic scan_last, scan_rlast, scan_first;

	// RAM.
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [11:0] ram_wdata, ram_rdata;

	// Output register.
	logic [7:0] out_glyph_q;
	logic [3:0] out_ink_q;
	logic out_changed_q, out_first_q, out_rlast_q, out_last_q;

	logic acc, wipe_done;

	// Terms watched by the assertions.
	logic wiping, show_first, draw_wr, in_window, takes_busy;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign wipe_done = (wipe_q == AW'(DEPTH - 1));

	always_comb begin
		if (cols_cfg_q == 8'd0) begin
			vis_cols = CW'(1);
		end else if (32'(cols_cfg_q) > MAX_COLS) begin
			vis_cols = CW'(MAX_COLS);
		end else begin
			vis_cols = CW'(cols_cfg_q);
		end
		if (rows_cfg_q == 6'd0) begin
			vis_rows = RW'(1);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			vis_rows = RW'(MAX_ROWS);
		end else begin
			vis_rows = RW'(rows_cfg_q);
		end
	end

	assign cols_s = signed'(CRD_W'(vis_cols));
	assign rows_s = signed'(CRD_W'(vis_rows));

	// Clipped bounding box of the captured shape.
	always_comb begin
		if (shape_q == SHAPE_ELLIPSE) begin
			none = (ew_q < 0);
			bx0 = (px_q - (ew_q <<< 1) > 0) ? px_q - (ew_q <<< 1) : '0;
			bx1 = (px_q + (ew_q <<< 1) < cols_s - CRD_W'(1)) ? px_q + (ew_q <<< 1) :
				cols_s - CRD_W'(1);
			by0 = (py_q - ew_q > 0) ? py_q - ew_q : '0;
			by1 = (py_q + ew_q < rows_s - CRD_W'(1)) ? py_q + ew_q : rows_s - CRD_W'(1);
		end else begin
			none = (ew_q <= 0) || (eh_q <= 0);
			bx0 = (px_q > 0) ? px_q : '0;
			bx1 = ((px_q + ew_q < cols_s) ? px_q + ew_q : cols_s) - CRD_W'(1);
			by0 = (py_q > 0) ? py_q : '0;
			by1 = ((py_q + eh_q < rows_s) ? py_q + eh_q : rows_s) - CRD_W'(1);
		end
		empty = none || (bx0 > bx1) || (by0 > by1);
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_TOTAL: begin
				mul_a = MUL_W'(vis_cols);
				mul_b = MUL_W'(vis_rows);
			end
			ST_MUL: begin
				if (shape_q == SHAPE_BAR) begin
					mul_a = MUL_W'(ew_q);
					mul_b = signed'({1'b0, frac_q});
				end else begin
					case (mstep_q)
						2'd0: mul_a = MUL_W'(ew_q <<< 1);
						2'd1: mul_a = MUL_W'(x0_q - px_q);
						2'd2: mul_a = MUL_W'((y_q - py_q) <<< 1);
						default: mul_a = '0;
					endcase
					mul_b = mul_a;
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Per-cell decision of the draw loop.
	assign dx       = x_q - px_q;
	assign dy       = y_q - py_q;
	assign interior = !solid_q && (dx > 0) && (dx < ew_q - 1) && (dy > 0) && (dy < eh_q - 1);
	assign row_end  = (x_q == x1_q);

	always_comb begin
		case (shape_q)
			SHAPE_RECT:    hit = !interior;
			SHAPE_ELLIPSE: hit = ((SQ_W + 1)'(dxsq_q) + (SQ_W + 1)'(dysq_q)) <= (SQ_W + 1)'(lim_q);
			SHAPE_BAR:     hit = 1'b1;
			default:       hit = 1'b0;
		endcase
	end

	// Bit-serial divider step: scan position over the visible width.
	assign div_t  = {rem_q, dq_q[AW-1]};
	assign div_ge = (div_t >= {1'b0, vis_cols});
	assign rem_n  = div_ge ? CW'(div_t - {1'b0, vis_cols}) : CW'(div_t);
	assign dq_n   = AW'({dq_q, div_ge});

	assign scan_first = (idx_q == '0);
	assign scan_last  = (row_q == vis_rows - RW'(1)) && (col_q == vis_cols - CW'(1));
	assign scan_rlast = (col_q == vis_cols - CW'(1)) && (row_q != vis_rows - RW'(1));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(32'(y_q) * MAX_COLS + 32'(x_q));
		ram_wdata = {ink_q, glyph_q};
		ram_raddr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
		if (state_q == ST_INIT || state_q == ST_WIPE) begin
			ram_we    = 1'b1;
			ram_waddr = wipe_q;
			ram_wdata = {4'd0, GLYPH_SPACE};
		end else if (state_q == ST_DRAW) begin
			ram_we = hit;
			if (shape_q == SHAPE_BAR) begin
				ram_wdata = (dx < filled_q) ? {ink_q, GLYPH_HASH} : {bink_q, GLYPH_DOT};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT, ST_WIPE: begin
				if (wipe_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (acc) begin
					case (cmd_t'(req.cmd))
						CMD_CLEAR:   state_d = ST_WIPE;
						CMD_CELL, CMD_RECT, CMD_ELLIPSE, CMD_BAR: state_d = ST_BOUNDS;
						CMD_SCAN:    state_d = need_div_q ? ST_TOTAL : ST_READ;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_BOUNDS: begin
				if (empty) begin
					state_d = ST_IDLE;
				end else if (shape_q == SHAPE_RECT) begin
					state_d = ST_DRAW;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (shape_q == SHAPE_BAR || mstep_q == 2'd2) state_d = ST_DRAW;
			end
			ST_DRAW: begin
				if (row_end && y_q == y1_q) state_d = ST_IDLE;
			end
			ST_TOTAL: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = ({1'b0, idx_q} >= total_q) ? ST_READ : ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == DCW'(AW - 1)) state_d = ST_READ;
			end
			ST_READ:  state_d = ST_RDATA;
			ST_RDATA: state_d = ST_OUT;
			ST_OUT: begin
				if (cells.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q   <= 8'd128;
			rows_cfg_q   <= 6'd32;
			wipe_q       <= '0;
			idx_q        <= '0;
			row_q        <= '0;
			col_q        <= '0;
			need_div_q   <= 1'b1;
			prev_ink_q   <= 4'd0;
			prev_valid_q <= 1'b0;
			mstep_q      <= 2'd0;
			dcnt_q       <= '0;
		end else begin
			if (state_q == ST_INIT || state_q == ST_WIPE) begin
				wipe_q <= wipe_q + AW'(1);
			end else if (acc) begin
				wipe_q <= '0;
			end
			if (state_q == ST_MUL) begin
				mstep_q <= mstep_q + 2'd1;
			end else begin
				mstep_q <= 2'd0;
			end
			if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + DCW'(1);
			end else begin
				dcnt_q <= '0;
			end
			if (state_q == ST_CHECK && {1'b0, idx_q} >= total_q) begin
				idx_q      <= '0;
				row_q      <= '0;
				col_q      <= '0;
				need_div_q <= 1'b0;
			end
			if (state_q == ST_DIV && dcnt_q == DCW'(AW - 1)) begin
				row_q      <= RW'(dq_n);
				col_q      <= rem_n;
				need_div_q <= 1'b0;
			end
			if (state_q == ST_RDATA) begin
				if (scan_last) begin
					idx_q        <= '0;
					row_q        <= '0;
					col_q        <= '0;
					prev_ink_q   <= 4'd0;
					prev_valid_q <= 1'b0;
				end else begin
					idx_q <= idx_q + AW'(1);
					if (col_q == vis_cols - CW'(1)) begin
						col_q <= '0;
						row_q <= row_q + RW'(1);
					end else begin
						col_q <= col_q + CW'(1);
					end
					prev_ink_q   <= ram_rdata[11:8];
					prev_valid_q <= 1'b1;
				end
			end
			// The scan position is split again by the divider after a window change.
			if (cfg_we && cfg_index == CFG_COLS) begin
				cols_cfg_q <= cfg_data;
				need_div_q <= 1'b1;
			end else if (cfg_we && cfg_index == CFG_ROWS) begin
				rows_cfg_q <= cfg_data[5:0];
				need_div_q <= 1'b1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (acc) begin
			px_q    <= CRD_W'(req.pos_x);
			py_q    <= CRD_W'(req.pos_y);
			glyph_q <= req.glyph;
			ink_q   <= fix_ink(req.ink);
			bink_q  <= fix_ink(req.back_ink);
			frac_q  <= (req.fraction > FRAC_FULL) ? FRAC_FULL : req.fraction;
			case (cmd_t'(req.cmd))
				CMD_CELL: begin
					ew_q    <= CRD_W'(1);
					eh_q    <= CRD_W'(1);
					solid_q <= 1'b1;
					shape_q <= SHAPE_RECT;
				end
				CMD_ELLIPSE: begin
					ew_q    <= CRD_W'(req.extent_w);
					eh_q    <= CRD_W'(req.extent_h);
					solid_q <= req.solid;
					shape_q <= SHAPE_ELLIPSE;
				end
				CMD_BAR: begin
					ew_q    <= CRD_W'(req.extent_w);
					eh_q    <= CRD_W'(1);
					solid_q <= 1'b1;
					shape_q <= SHAPE_BAR;
				end
				default: begin
					ew_q    <= CRD_W'(req.extent_w);
					eh_q    <= CRD_W'(req.extent_h);
					solid_q <= req.solid;
					shape_q <= SHAPE_RECT;
				end
			endcase
		end
		if (state_q == ST_BOUNDS) begin
			x0_q <= bx0;
			x1_q <= bx1;
			y1_q <= by1;
			x_q  <= bx0;
			y_q  <= by0;
		end
		if (state_q == ST_MUL) begin
			if (shape_q == SHAPE_BAR) begin
				filled_q <= CRD_W'(prod >>> 16);
			end else begin
				case (mstep_q)
					2'd0: lim_q <= SQ_W'(prod);
					2'd1: begin
						dxsq0_q <= SQ_W'(prod);
						dxsq_q  <= SQ_W'(prod);
					end
					2'd2: dysq_q <= SQ_W'(prod);
					default: lim_q <= lim_q;
				endcase
			end
		end
		if (state_q == ST_DRAW) begin
			// Squared distances advance by first differences along the walk.
			if (row_end) begin
				x_q    <= x0_q;
				y_q    <= y_q + CRD_W'(1);
				dxsq_q <= dxsq0_q;
				dysq_q <= dysq_q + (SQ_W'(dy) <<< 3) + SQ_W'(4);
			end else begin
				x_q    <= x_q + CRD_W'(1);
				dxsq_q <= dxsq_q + (SQ_W'(dx) <<< 1) + SQ_W'(1);
			end
		end
		if (state_q == ST_TOTAL) begin
			total_q <= TW'(prod);
		end
		if (state_q == ST_CHECK) begin
			dq_q  <= idx_q;
			rem_q <= '0;
		end
		if (state_q == ST_DIV) begin
			dq_q  <= dq_n;
			rem_q <= rem_n;
		end
		if (state_q == ST_RDATA) begin
			out_glyph_q   <= ram_rdata[7:0];
			out_ink_q     <= ram_rdata[11:8];
			out_changed_q <= scan_first || !prev_valid_q || (ram_rdata[11:8] != prev_ink_q);
			out_first_q   <= scan_first;
			out_rlast_q   <= scan_rlast;
			out_last_q    <= scan_last;
		end
	end

	cfr_ram #(
		.WIDTH (12),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cells.valid       = (state_q == ST_OUT);
	assign cells.cell_glyph  = out_glyph_q;
	assign cells.cell_ink    = out_ink_q;
	assign cells.ink_changed = out_changed_q;
	assign cells.frame_first = out_first_q;
	assign cells.row_last    = out_rlast_q;
	assign cells.frame_last  = out_last_q;

	// Every command but the two unused codes leaves the idle state in the cycle after it is taken.
	assign wiping     = (state_q == ST_INIT || state_q == ST_WIPE);
	assign show_first = cells.valid && cells.frame_first;
	assign draw_wr    = ram_we && (state_q == ST_DRAW);
	assign in_window  = (x_q >= 0) && (x_q < cols_s) && (y_q >= 0) && (y_q < rows_s);
	assign takes_busy = acc && (req.cmd <= CMD_SCAN);

	`CFR_ASSERT_IMP(a_wipe_no_result, wiping, !cells.valid, "result during a clearing sweep")
	`CFR_ASSERT_IMP(a_first_change, show_first, cells.ink_changed, "frame start, no color change")
	`CFR_ASSERT_IMP(a_draw_in_window, draw_wr, in_window, "draw write outside the window")
	`CFR_ASSERT_NXT(a_busy_after_accept, takes_busy, !req.ready, "command taken, block not busy")

endmodule
